@@ design/lde_pkg.sv @@
`timescale 1ns / 1ps

package lde_pkg;

	localparam logic [1:0] MODE_OD = 2'd0;
	localparam logic [1:0] MODE_UD = 2'd1;
	localparam logic [1:0] MODE_MEM = 2'd2;

	localparam logic CMD_RESET = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_TIME_STEP = 3'd1;
	localparam logic [2:0] REG_DRIFT_GAIN = 3'd2;
	localparam logic [2:0] REG_FRICTION = 3'd3;
	localparam logic [2:0] REG_NOISE_SCALE = 3'd4;
	localparam logic [2:0] REG_KERNEL_DECAY = 3'd5;
	localparam logic [2:0] REG_START_POS = 3'd6;
	localparam logic [2:0] REG_START_VEL = 3'd7;

	localparam logic [16:0] DECAY_RESET = 17'd24109;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [3:0] {
		OP_KICK,
		OP_XG,
		OP_GDT,
		OP_FF,
		OP_ADT,
		OP_VDT,
		OP_ALU_OD,
		OP_ALU_ACC,
		OP_ALU_V,
		OP_ALU_X,
		OP_PUSH,
		OP_DONE
	} op_t;

	typedef struct packed {
		logic load_start;
		logic step_start;
		logic walk_step;
		logic exec;
		op_t  op;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_last;
		logic walk_busy;
		logic mul_done;
	} dp_stat_t;

	function automatic op_t uop(input logic [1:0] mode, input logic [3:0] idx);
		op_t op;
		op = OP_DONE;
		if (mode == MODE_OD) begin
			case (idx)
				4'd0: op = OP_KICK;
				4'd1: op = OP_XG;
				4'd2: op = OP_GDT;
				4'd3: op = OP_ALU_OD;
				default: op = OP_DONE;
			endcase
		end else if (mode == MODE_UD || mode == MODE_MEM) begin
			case (idx)
				4'd0: op = OP_KICK;
				4'd1: op = OP_XG;
				4'd2: op = OP_FF;
				4'd3: op = OP_ALU_ACC;
				4'd4: op = OP_ADT;
				4'd5: op = OP_ALU_V;
				4'd6: op = OP_VDT;
				4'd7: op = OP_ALU_X;
				4'd8: op = (mode == MODE_MEM) ? OP_PUSH : OP_DONE;
				default: op = OP_DONE;
			endcase
		end
		return op;
	endfunction

	function automatic logic is_mul(input op_t op);
		logic m;
		case (op)
			OP_KICK, OP_XG, OP_GDT, OP_FF, OP_ADT, OP_VDT: m = 1'b1;
			default: m = 1'b0;
		endcase
		return m;
	endfunction

	// Rounds a product to nearest with ties away from zero, then saturates.
	function automatic logic signed [31:0] qround(input logic signed [65:0] p,
			input int unsigned frac);
		logic [66:0] mag;
		logic [66:0] r;
		logic signed [31:0] res;
		mag = p[65] ? (67'd0 - {p[65], p}) : {1'b0, p};
		r = (mag + (67'd1 << (frac - 1))) >> frac;
		if (!p[65]) begin
			res = (r > 67'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(r[31:0]);
		end else begin
			res = (r > 67'h8000_0000) ? 32'sh8000_0000 : signed'(32'd0 - r[31:0]);
		end
		return res;
	endfunction

	function automatic logic signed [31:0] sat35(input logic signed [34:0] s);
		logic signed [31:0] res;
		if (s > 35'sh0_7FFF_FFFF) begin
			res = 32'sh7FFF_FFFF;
		end else if (s < -35'sh0_8000_0000) begin
			res = 32'sh8000_0000;
		end else begin
			res = s[31:0];
		end
		return res;
	endfunction

endpackage

@@ design/lde_ctrl.sv @@
`timescale 1ns / 1ps

module lde_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [1:0]        mode,
	output logic              out_valid,
	input  logic              out_ready,
	output lde_pkg::dp_cmd_t  cmd,
	input  lde_pkg::dp_stat_t stat
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_WALK  = 6'b000010,
		S_DRAIN = 6'b000100,
		S_EXEC  = 6'b001000,
		S_MWAIT = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	logic [3:0] upc_q;
	logic out_valid_q;
	logic accept;
	lde_pkg::op_t op;

	assign op = lde_pkg::uop(mode, upc_q);
	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load_start = accept && (command == lde_pkg::CMD_RESET);
		cmd.step_start = accept && (command == lde_pkg::CMD_STEP);
		cmd.walk_step = (state_q == S_WALK);
		cmd.exec = (state_q == S_EXEC) && (op != lde_pkg::OP_DONE);
		cmd.op = op;
		cmd.load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			upc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					upc_q <= '0;
					if (accept) begin
						if (command == lde_pkg::CMD_RESET) begin
							state_q <= S_DONE;
						end else if (mode == lde_pkg::MODE_MEM) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_WALK: begin
					if (stat.walk_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!stat.walk_busy) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op == lde_pkg::OP_DONE) begin
						state_q <= S_DONE;
					end else begin
						upc_q <= upc_q + 4'd1;
						if (lde_pkg::is_mul(op)) begin
							state_q <= S_MWAIT;
						end
					end
				end
				S_MWAIT: begin
					if (stat.mul_done) begin
						state_q <= S_EXEC;
					end
				end
				S_DONE: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_walk_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (mode == lde_pkg::MODE_MEM))
		else $error("history walk outside memory mode");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q && (state_q == S_IDLE))
		else $error("result not presented after completion");

endmodule

@@ design/lde_datapath.sv @@
`timescale 1ns / 1ps

module lde_datapath #(
	parameter int MEM_DEPTH = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lde_pkg::dp_cmd_t    cmd,
	output lde_pkg::dp_stat_t   stat,
	input  logic [1:0]          mode,
	input  logic [31:0]         time_step,
	input  logic [31:0]         drift_gain,
	input  logic [31:0]         friction,
	input  logic [31:0]         noise_scale,
	input  logic [16:0]         kernel_decay,
	input  logic signed [31:0]  start_position,
	input  logic signed [31:0]  start_velocity,
	input  logic signed [31:0]  noise,
	output logic [47:0]         elapsed_time,
	output logic signed [31:0]  position,
	output logic signed [31:0]  velocity
);

	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int CW = $clog2(MEM_DEPTH + 1);
	localparam int SW = 32 + CW + 1;
	localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(MEM_DEPTH);
	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
	localparam logic signed [SW-1:0] SMAX = SW'(64'sh7FFF_FFFF);
	localparam logic signed [SW-1:0] SMIN = SW'(-64'sh8000_0000);

	logic signed [31:0] mem [MEM_DEPTH];

	logic signed [31:0] x_q, v_q, noise_q, kick_q, g_q, f_q, acc_q;
	logic [47:0] t_q;
	logic [AW-1:0] wp_q, rp_q, idx_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] w_q, w_s1;
	logic signed [31:0] rd_s1, term_s3;
	logic wv_s1, pw_s1, pw_s2, pw_s3, po_s2;
	lde_pkg::op_t op_s2;
	logic signed [65:0] prod_s2;
	logic signed [SW-1:0] wsum_q;
	logic [47:0] out_time_q;
	logic signed [31:0] out_pos_q, out_vel_q;

	logic [31:0] decay_eff;
	logic [63:0] wprod;
	logic [31:0] w_next;
	logic signed [31:0] fric_mem;
	logic signed [31:0] op_a, mul_a;
	logic [31:0] op_b, mul_b;
	logic signed [31:0] rnd;
	logic [48:0] t_sum;

	assign decay_eff = ({15'd0, kernel_decay} > ONE) ? ONE : {15'd0, kernel_decay};
	assign wprod = 64'(w_q) * 64'(decay_eff);
	assign w_next = 32'((wprod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	assign t_sum = {1'b0, t_q} + 49'(time_step);
	assign rnd = lde_pkg::qround(prod_s2, FRAC_BITS);

	always_comb begin
		if (wsum_q > SMAX) begin
			fric_mem = 32'sh7FFF_FFFF;
		end else if (wsum_q < SMIN) begin
			fric_mem = 32'sh8000_0000;
		end else begin
			fric_mem = wsum_q[31:0];
		end
	end

	always_comb begin
		case (cmd.op)
			lde_pkg::OP_KICK: begin
				op_a = noise_q;
				op_b = noise_scale;
			end
			lde_pkg::OP_XG: begin
				op_a = x_q;
				op_b = drift_gain;
			end
			lde_pkg::OP_GDT: begin
				op_a = g_q;
				op_b = time_step;
			end
			lde_pkg::OP_FF: begin
				op_a = (mode == lde_pkg::MODE_MEM) ? fric_mem : v_q;
				op_b = friction;
			end
			lde_pkg::OP_ADT: begin
				op_a = acc_q;
				op_b = time_step;
			end
			lde_pkg::OP_VDT: begin
				op_a = v_q;
				op_b = time_step;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		if (pw_s1) begin
			mul_a = wv_s1 ? rd_s1 : 32'sd0;
			mul_b = w_s1;
		end else begin
			mul_a = op_a;
			mul_b = op_b;
		end
	end

	always_comb begin
		stat.walk_last = (idx_q == LAST);
		stat.walk_busy = pw_s1 || pw_s2 || pw_s3;
		stat.mul_done = po_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && cmd.op == lde_pkg::OP_PUSH) begin
			mem[wp_q] <= v_q;
		end
		if (cmd.walk_step) begin
			rd_s1 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 66'(signed'({mul_a[31], mul_a})) * 66'(signed'({1'b0, mul_b}));
		op_s2 <= cmd.op;
		term_s3 <= rnd;
		if (cmd.walk_step) begin
			wv_s1 <= (CW'(idx_q) < cnt_q);
			w_s1 <= w_q;
		end
		if (cmd.step_start) begin
			noise_q <= noise;
		end
		if (po_s2) begin
			case (op_s2)
				lde_pkg::OP_KICK: kick_q <= rnd;
				lde_pkg::OP_FF: f_q <= rnd;
				default: g_q <= rnd;
			endcase
		end
		if (cmd.exec && cmd.op == lde_pkg::OP_ALU_ACC) begin
			acc_q <= lde_pkg::sat35(35'sd0 - 35'(g_q) - 35'(f_q));
		end
		if (cmd.load_out) begin
			out_time_q <= t_q;
			out_pos_q <= x_q;
			out_vel_q <= v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			v_q <= '0;
			t_q <= '0;
			wp_q <= '0;
			cnt_q <= '0;
			rp_q <= '0;
			idx_q <= '0;
			w_q <= ONE;
			wsum_q <= '0;
			pw_s1 <= 1'b0;
			pw_s2 <= 1'b0;
			pw_s3 <= 1'b0;
			po_s2 <= 1'b0;
		end else begin
			pw_s1 <= cmd.walk_step;
			pw_s2 <= pw_s1;
			pw_s3 <= pw_s2;
			po_s2 <= cmd.exec && lde_pkg::is_mul(cmd.op);
			if (pw_s3) begin
				wsum_q <= wsum_q + SW'(term_s3);
			end
			if (cmd.load_start) begin
				x_q <= start_position;
				v_q <= start_velocity;
				t_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.step_start) begin
				t_q <= t_sum[48] ? lde_pkg::TIME_MAX : t_sum[47:0];
				rp_q <= (wp_q == '0) ? LAST : wp_q - AW'(1);
				idx_q <= '0;
				w_q <= ONE;
				wsum_q <= '0;
			end
			if (cmd.walk_step) begin
				rp_q <= (rp_q == '0) ? LAST : rp_q - AW'(1);
				idx_q <= idx_q + AW'(1);
				w_q <= w_next;
			end
			if (cmd.exec) begin
				case (cmd.op)
					lde_pkg::OP_ALU_OD: begin
						x_q <= lde_pkg::sat35(35'(x_q) - 35'(g_q) + 35'(kick_q));
						v_q <= '0;
					end
					lde_pkg::OP_ALU_V: begin
						v_q <= lde_pkg::sat35(35'(v_q) + 35'(g_q) + 35'(kick_q));
					end
					lde_pkg::OP_ALU_X: begin
						x_q <= lde_pkg::sat35(35'(x_q) + 35'(g_q));
					end
					lde_pkg::OP_PUSH: begin
						wp_q <= (wp_q == LAST) ? '0 : wp_q + AW'(1);
						if (cnt_q != DEPTH_C) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign elapsed_time = out_time_q;
	assign position = out_pos_q;
	assign velocity = out_vel_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= DEPTH_C)
		else $error("history fill count beyond depth");
	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n) wp_q <= LAST)
		else $error("history write pointer beyond depth");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(pw_s1 && cmd.exec && lde_pkg::is_mul(cmd.op)))
		else $error("history walk and update share the multiplier");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_start |=> (t_q == '0) && (cnt_q == '0))
		else $error("reset command did not clear time and history");

endmodule

@@ design/langevin_dynamics_step.sv @@
`timescale 1ns / 1ps

// Langevin particle stepper: one Euler-Maruyama step per input transfer.
// Configuration transfers (cfg_valid/cfg_ready, cfg_index, cfg_data) write the
// mode, time step, gains, noise scale, kernel decay and start state; they are
// always accepted and must only be made while the block is idle.
// An input transfer carries a command (reset or step) and a noise sample; each
// yields exactly one output transfer with elapsed time, position and velocity.
// In memory mode the step first walks all MEM_DEPTH history entries through the
// shared multiplier, one entry per cycle. One item is processed at a time, and the
// next input transfer can be accepted in the cycle after the result is loaded.
// The result waits in an output register; while the receiver stalls, one more
// item is accepted and computed, and the input is then held off until that
// register is free to take its result.
// Reset clears position, velocity, time and the history fill count and loads
// the default configuration; no clearing pass over the history is needed.
module langevin_dynamics_step #(
	parameter int MEM_DEPTH = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [31:0] noise,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [47:0]        elapsed_time,
	output logic signed [31:0] position,
	output logic signed [31:0] velocity
);

	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	logic [1:0] mode_q;
	logic [31:0] time_step_q, drift_gain_q, friction_q, noise_scale_q;
	logic [16:0] kernel_decay_q;
	logic signed [31:0] start_pos_q, start_vel_q;
	lde_pkg::dp_cmd_t cmd;
	lde_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lde_pkg::MODE_UD;
			time_step_q <= ONE;
			drift_gain_q <= ONE;
			friction_q <= '0;
			noise_scale_q <= '0;
			kernel_decay_q <= lde_pkg::DECAY_RESET;
			start_pos_q <= '0;
			start_vel_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lde_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				lde_pkg::REG_TIME_STEP: time_step_q <= cfg_data;
				lde_pkg::REG_DRIFT_GAIN: drift_gain_q <= cfg_data;
				lde_pkg::REG_FRICTION: friction_q <= cfg_data;
				lde_pkg::REG_NOISE_SCALE: noise_scale_q <= cfg_data;
				lde_pkg::REG_KERNEL_DECAY: kernel_decay_q <= cfg_data[16:0];
				lde_pkg::REG_START_POS: start_pos_q <= cfg_data;
				lde_pkg::REG_START_VEL: start_vel_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.mode      (mode_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	lde_datapath #(
		.MEM_DEPTH (MEM_DEPTH),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.mode           (mode_q),
		.time_step      (time_step_q),
		.drift_gain     (drift_gain_q),
		.friction       (friction_q),
		.noise_scale    (noise_scale_q),
		.kernel_decay   (kernel_decay_q),
		.start_position (start_pos_q),
		.start_velocity (start_vel_q),
		.noise          (noise),
		.elapsed_time   (elapsed_time),
		.position       (position),
		.velocity       (velocity)
	);

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] MODE_HOLD = 2'd3;
	localparam int HIST_DEPTH = 1024;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  idx;
		logic [31:0] data;
		logic        cmd;
		logic [31:0] nz;
		bit          typed;
		logic [47:0] t_exp;
		logic [31:0] p_exp;
		logic [31:0] v_exp;
	} row_t;

	typedef struct {
		logic [47:0] t;
		logic [31:0] p;
		logic [31:0] v;
	} state_out_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic command;
	logic signed [31:0] noise;
	logic out_valid;
	logic out_ready;
	logic [47:0] elapsed_time;
	logic signed [31:0] position;
	logic signed [31:0] velocity;

	langevin_dynamics_step u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .noise(noise),
		.out_valid(out_valid), .out_ready(out_ready), .elapsed_time(elapsed_time),
		.position(position), .velocity(velocity)
	);

	logic [1:0] m_mode;
	longint unsigned m_dt, m_gain, m_fric, m_nscale, m_decay;
	longint m_start_x, m_start_v;
	longint cur_x, cur_v;
	longint unsigned cur_t;
	longint vel_hist[HIST_DEPTH];

	state_out_t expected_q[$];
	bit failed;
	bit hold_req;
	int unsigned cyc = 0;
	int unsigned stall_cnt = 0;

	row_t dir_tbl[] = '{
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h0,
			1, 48'd65536, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_RESET, 32'h0,
			1, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_START_POS, 32'h7FFF_FFFF, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_START_VEL, 32'h8000_0000, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_RESET, 32'h0,
			1, 48'd0, 32'h7FFF_FFFF, 32'h8000_0000},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h7FFF_FFFF,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_NOISE_SCALE, 32'hFFFF_FFFF, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h8000_0000,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h7FFF_FFFF,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_MODE, 32'(lde_pkg::MODE_OD), lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h1234_5678,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h8000_0000,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_TIME_STEP, 32'h0, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_TIME_STEP, 32'hFFFF_FFFF, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_DRIFT_GAIN, 32'hFFFF_FFFF, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h1,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_MODE, 32'(lde_pkg::MODE_MEM), lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_FRICTION, 32'h0001_0000, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_TIME_STEP, 32'h0000_1000, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_NOISE_SCALE, 32'h0001_0000, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_DRIFT_GAIN, 32'h0, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_RESET, 32'h0,
			1, 48'd0, 32'h7FFF_FFFF, 32'h8000_0000},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'hFFFF_0000,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h0002_0000,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_KERNEL_DECAY, 32'h0001_FFFF, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h7FFF_FFFF,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h8000_0000,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_KERNEL_DECAY, 32'h0, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h1,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_MODE, 32'(MODE_HOLD), lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h5555_5555,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'hAAAA_AAAA,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_MODE, 32'(lde_pkg::MODE_UD), lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_START_POS, 32'h0, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_START_VEL, 32'h0, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{1, lde_pkg::REG_FRICTION, 32'hFFFF_FFFF, lde_pkg::CMD_STEP, 32'h0,
			0, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_RESET, 32'h0,
			1, 48'd0, 32'h0, 32'h0},
		'{0, lde_pkg::REG_MODE, 32'h0, lde_pkg::CMD_STEP, 32'h4000_0000,
			0, 48'd0, 32'h0, 32'h0}
	};

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Product rounded to nearest with ties away from zero, then saturated.
	function automatic longint fx_mul(input longint a, input longint unsigned b);
		longint unsigned mag;
		longint unsigned r;
		bit neg;
		neg = a < 0;
		mag = neg ? longint'(-a) : a;
		r = (mag * (b & 64'h1_FFFF_FFFF) + 64'd32768) >> 16;
		return sat32(neg ? -longint'(r) : longint'(r));
	endfunction

	function automatic state_out_t advance_particle(input logic cmd, input logic [31:0] nz);
		longint kick, fric, acc, w, sum;
		longint unsigned t, dec;
		state_out_t r;
		if (cmd == lde_pkg::CMD_RESET) begin
			cur_x = m_start_x;
			cur_v = m_start_v;
			cur_t = 0;
			for (int i = 0; i < HIST_DEPTH; i++) vel_hist[i] = 0;
		end else begin
			kick = fx_mul(longint'(signed'(nz)), m_nscale);
			t = cur_t + m_dt;
			cur_t = (t > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : t;
			if (m_mode == lde_pkg::MODE_OD) begin
				cur_x = sat32(cur_x - fx_mul(fx_mul(cur_x, m_gain), m_dt) + kick);
				cur_v = 0;
			end else if (m_mode == lde_pkg::MODE_UD || m_mode == lde_pkg::MODE_MEM) begin
				if (m_mode == lde_pkg::MODE_UD) begin
					fric = cur_v;
				end else begin
					dec = (m_decay > 64'd65536) ? 64'd65536 : m_decay;
					w = 65536;
					sum = 0;
					for (int i = 0; i < HIST_DEPTH; i++) begin
						sum += fx_mul(vel_hist[i], w);
						w = fx_mul(w, dec);
					end
					fric = sat32(sum);
				end
				acc = sat32(-fx_mul(cur_x, m_gain) - fx_mul(fric, m_fric));
				cur_v = sat32(cur_v + fx_mul(acc, m_dt) + kick);
				cur_x = sat32(cur_x + fx_mul(cur_v, m_dt));
				if (m_mode == lde_pkg::MODE_MEM) begin
					for (int i = HIST_DEPTH - 1; i > 0; i--) vel_hist[i] = vel_hist[i - 1];
					vel_hist[0] = cur_v;
				end
			end
		end
		r.t = cur_t[47:0];
		r.p = cur_x[31:0];
		r.v = cur_v[31:0];
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	function automatic bit quiet_window();
		return ((cyc / 3000) % 4) == 1;
	endfunction

	task automatic send_step(input logic cmd, input logic [31:0] nz, input bit typed,
			input state_out_t typed_res);
		state_out_t r;
		in_valid <= 1'b1;
		command <= cmd;
		noise <= nz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = advance_particle(cmd, nz);
		expected_q.push_back(typed ? typed_res : r);
		@(negedge clk);
		if (!quiet_window() && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			lde_pkg::REG_MODE: m_mode = data[1:0];
			lde_pkg::REG_TIME_STEP: m_dt = data;
			lde_pkg::REG_DRIFT_GAIN: m_gain = data;
			lde_pkg::REG_FRICTION: m_fric = data;
			lde_pkg::REG_NOISE_SCALE: m_nscale = data;
			lde_pkg::REG_KERNEL_DECAY: m_decay = data[16:0];
			lde_pkg::REG_START_POS: m_start_x = longint'(signed'(data));
			lde_pkg::REG_START_VEL: m_start_v = longint'(signed'(data));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_gain();
		return ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 32'h0002_0000);
	endfunction

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= quiet_window() ? 1'b1 : ($urandom_range(99) >= 7);
			end
		end
	end

	always @(posedge clk) begin
		state_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("Result transfer with no expected result: time %0d", elapsed_time);
				failed = 1'b1;
			end else begin
				e = expected_q.pop_front();
				if (elapsed_time !== e.t) begin
					$error("elapsed_time: expected %0d, got %0d", e.t, elapsed_time);
					failed = 1'b1;
				end
				if (position !== e.p) begin
					$error("position: expected %0h, got %0h", e.p, position);
					failed = 1'b1;
				end
				if (velocity !== e.v) begin
					$error("velocity: expected %0h, got %0h", e.v, velocity);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		state_out_t tr;
		logic [1:0] md;
		int unsigned sel;
		logic [31:0] nz;
		failed = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = lde_pkg::REG_MODE;
		cfg_data = 32'h0;
		in_valid = 1'b0;
		command = lde_pkg::CMD_STEP;
		noise = 32'sh0;
		m_mode = lde_pkg::MODE_UD;
		m_dt = 65536;
		m_gain = 65536;
		m_fric = 0;
		m_nscale = 0;
		m_decay = 24109;
		m_start_x = 0;
		m_start_v = 0;
		cur_x = 0;
		cur_v = 0;
		cur_t = 0;
		for (int i = 0; i < HIST_DEPTH; i++) vel_hist[i] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tbl[k]) begin
			if (dir_tbl[k].is_cfg) begin
				drain_results();
				write_reg(dir_tbl[k].idx, dir_tbl[k].data);
			end else begin
				tr.t = dir_tbl[k].t_exp;
				tr.p = dir_tbl[k].p_exp;
				tr.v = dir_tbl[k].v_exp;
				send_step(dir_tbl[k].cmd, dir_tbl[k].nz, dir_tbl[k].typed, tr);
			end
		end

		for (int ph = 0; ph < 9; ph++) begin
			drain_results();
			sel = $urandom_range(9);
			md = (sel < 3) ? lde_pkg::MODE_MEM : (sel < 6) ? lde_pkg::MODE_UD :
				(sel < 8) ? lde_pkg::MODE_OD : MODE_HOLD;
			write_reg(lde_pkg::REG_MODE, {30'($urandom_range(0, 32'h3FFF_FFFF)), md});
			write_reg(lde_pkg::REG_TIME_STEP, ($urandom_range(5) == 0) ? $urandom() :
				$urandom_range(0, 32'h4000));
			write_reg(lde_pkg::REG_DRIFT_GAIN, pick_gain());
			write_reg(lde_pkg::REG_FRICTION, pick_gain());
			write_reg(lde_pkg::REG_NOISE_SCALE, pick_gain());
			write_reg(lde_pkg::REG_KERNEL_DECAY, ($urandom_range(3) == 0) ? $urandom() :
				$urandom_range(0, 32'h0001_0000));
			write_reg(lde_pkg::REG_START_POS, ($urandom_range(1) == 0) ? $urandom() :
				$urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
			write_reg(lde_pkg::REG_START_VEL, ($urandom_range(1) == 0) ? $urandom() :
				$urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
			for (int n = 0; n < 48; n++) begin
				if (ph == 2 && n == 10) hold_req = 1'b1;
				if (ph == 4 && n == 24) drain_results();
				nz = ($urandom_range(1) == 0) ? $urandom() :
					$urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
				send_step(($urandom_range(99) < 5) ? lde_pkg::CMD_RESET : lde_pkg::CMD_STEP,
					nz, 1'b0, tr);
			end
		end

		drain_results();
		repeat (100) @(negedge clk);
		if (!failed && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/lde_pkg.sv
design/lde_ctrl.sv
design/lde_datapath.sv
design/langevin_dynamics_step.sv
tb/sv/tb_top.sv
